// ===== design/msh_pkg.sv =====
package msh_pkg;

  localparam logic [63:0] P1 = 64'hFFFFFFFFFFFFFFC5;
  localparam logic [63:0] P2 = 64'hFFFFFFFFFFFFFFAD;
  localparam logic [6:0]  C1 = 7'd59;
  localparam logic [6:0]  C2 = 7'd83;
  localparam logic [63:0] TRIG_CONST = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SEED = 64'h0123456789ABCDEF;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_PERM, ST_WAIT, ST_OUT, ST_RELOAD
  } ctl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_init;
    logic absorb;
    logic start_perm;
  } dp_cmd_t;

  typedef struct packed {
    logic perm_busy;
    logic perm_done;
  } dp_sts_t;

  function automatic logic [8:0] prime_at(input logic [5:0] i);
    logic [8:0] p;
    begin
      unique case (i)
        6'd0: p = 9'd3;    6'd1: p = 9'd5;    6'd2: p = 9'd7;    6'd3: p = 9'd11;
        6'd4: p = 9'd13;   6'd5: p = 9'd17;   6'd6: p = 9'd19;   6'd7: p = 9'd23;
        6'd8: p = 9'd29;   6'd9: p = 9'd31;   6'd10: p = 9'd37;  6'd11: p = 9'd41;
        6'd12: p = 9'd43;  6'd13: p = 9'd47;  6'd14: p = 9'd53;  6'd15: p = 9'd59;
        6'd16: p = 9'd61;  6'd17: p = 9'd67;  6'd18: p = 9'd71;  6'd19: p = 9'd73;
        6'd20: p = 9'd79;  6'd21: p = 9'd83;  6'd22: p = 9'd89;  6'd23: p = 9'd97;
        6'd24: p = 9'd101; 6'd25: p = 9'd103; 6'd26: p = 9'd107; 6'd27: p = 9'd109;
        6'd28: p = 9'd113; 6'd29: p = 9'd127; 6'd30: p = 9'd131; 6'd31: p = 9'd137;
        6'd32: p = 9'd139; 6'd33: p = 9'd149; 6'd34: p = 9'd151; 6'd35: p = 9'd157;
        6'd36: p = 9'd163; 6'd37: p = 9'd167; 6'd38: p = 9'd173; 6'd39: p = 9'd179;
        6'd40: p = 9'd181; 6'd41: p = 9'd191; 6'd42: p = 9'd193; 6'd43: p = 9'd197;
        6'd44: p = 9'd199; 6'd45: p = 9'd211; 6'd46: p = 9'd223; 6'd47: p = 9'd227;
        6'd48: p = 9'd229; 6'd49: p = 9'd233; 6'd50: p = 9'd239; 6'd51: p = 9'd241;
        6'd52: p = 9'd251; 6'd53: p = 9'd257; 6'd54: p = 9'd263; 6'd55: p = 9'd269;
        6'd56: p = 9'd271; 6'd57: p = 9'd277; 6'd58: p = 9'd281; 6'd59: p = 9'd283;
        6'd60: p = 9'd293; 6'd61: p = 9'd307; 6'd62: p = 9'd311; default: p = 9'd313;
      endcase
      return p;
    end
  endfunction

  // first fold of the high half: lo + hi * c, fits in 72 bits
  function automatic logic [71:0] fold_hi(input logic [127:0] w, input logic [6:0] c);
    logic [71:0] s;
    begin
      s = {8'd0, w[63:0]} + {8'd0, w[127:64]} * {65'd0, c};
      return s;
    end
  endfunction

  // second fold, carry fold, one conditional subtract
  function automatic logic [63:0] fold_lo(input logic [71:0] s, input logic [6:0] c,
                                          input logic [63:0] p);
    logic [71:0]  t;
    logic [64:0]  r;
    begin
      t = {8'd0, s[63:0]} + {64'd0, s[71:64]} * {65'd0, c};
      r = {1'b0, t[63:0]};
      if (t[64]) r = {1'b0, t[63:0]} + {58'd0, c};
      if (r[63:0] >= p) r = {1'b0, r[63:0] - p};
      return r[63:0];
    end
  endfunction

endpackage

// ===== design/modmul_sponge_hash256.sv =====
// channel | direction | ports
// input   | in        | in_valid, in_stall, in_msg_word, in_last_block, in_valid_bytes
// result  | out       | out_valid, out_stall, out_digest_word, out_word_index, out_digest_last
// one permutation: 64 trigger-bit steps, two prime products per set bit and 10
// lane multiplies on one shared multiplier; each multiply runs four 32x32
// partial products, two fold steps and a handoff
// reset loads the seeded lanes and runs one permutation before the first beat
// results are held while out_stall is high; no input beat is taken meanwhile
module modmul_sponge_hash256 import msh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_msg_word,
  input  logic        in_last_block,
  input  logic [2:0]  in_valid_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_digest_last
);
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [63:0] word, mask, pad;

  always_comb begin
    mask = (64'd1 << {in_valid_bytes, 3'b000}) - 64'd1;
    pad  = {56'd0, PAD_BYTE} << {in_valid_bytes, 3'b000};
    word = in_last_block ? ((in_msg_word & mask) | pad) : in_msg_word;
  end

  msh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_last(in_last_block),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .word_index(out_word_index), .digest_last(out_digest_last), .sts(sts), .cmd(cmd)
  );

  msh_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .absorb_word(word), .sts(sts),
    .lane0(out_digest_word)
  );
endmodule

// ===== design/msh_mulmod.sv =====
// 64x64 modular multiply, 4 partial products of 32x32, one per cycle,
// then the two folds
module msh_mulmod import msh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic        sel2,
  output logic        done,
  output logic [63:0] res
);
  logic [63:0]  a_r, b_r;
  logic         sel2_r;
  logic [127:0] acc_r, acc_nxt;
  logic [2:0]   step_r, step_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [63:0]  res_r, res_nxt;
  logic [31:0]  ma, mb;
  logic [63:0]  pp_r;
  logic [1:0]   pidx_r;

  always_comb begin
    ma = step_r[0] ? a_r[63:32] : a_r[31:0];
    mb = step_r[1] ? b_r[63:32] : b_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      sel2_r <= sel2;
    end
    pp_r   <= ma * mb;
    pidx_r <= step_r[1:0];
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    acc_nxt  = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    if (start) begin
      acc_nxt  = '0;
      step_nxt = 3'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      step_nxt = step_r + 3'd1;
      if (step_r >= 3'd1 && step_r <= 3'd4)
        acc_nxt = acc_r + ({64'd0, pp_r} << (32 * (pidx_r[0] + pidx_r[1])));
      if (step_r == 3'd5)
        acc_nxt = {56'd0, fold_hi(acc_r, sel2_r ? C2 : C1)};
      if (step_r == 3'd6) begin
        res_nxt  = fold_lo(acc_r[71:0], sel2_r ? C2 : C1, sel2_r ? P2 : P1);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  assign done = done_r;
  assign res  = res_r;
endmodule

// ===== design/msh_datapath.sv =====
// lane registers and permutation sequencer around one shared modular multiplier
module msh_datapath import msh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [63:0] absorb_word,
  output dp_sts_t     sts,
  output logic [63:0] lane0
);
  logic [63:0] lane_r [5];
  logic [63:0] t_r [5];
  logic [63:0] pr1_r, pr2_r, trig_r;
  // phase: 0 products over trigger bits, 1 squares, 2 times product, 3 mix
  logic [1:0]  ph_r;
  logic [6:0]  bit_r;
  logic [2:0]  ln_r;
  logic        ssel_r;
  logic        busy_r, wait_r, done_r;
  logic        m_start, m_done, m_sel2;
  logic [63:0] m_a, m_b, m_res;
  logic [63:0] s0, s1, s2, s3, s4;

  msh_mulmod u_mul (
    .clk(clk), .rst_n(rst_n), .start(m_start), .a(m_a), .b(m_b),
    .sel2(m_sel2), .done(m_done), .res(m_res)
  );

  always_comb begin
    s0 = SEED + 64'hDEADBEEFCAFEBABE;
    s1 = SEED ^ 64'h13198A2E03707344;
    s2 = SEED + 64'h9E3779B97F4A7C15;
    s3 = SEED ^ 64'hBF58476D1CE4E5B9;
    s4 = SEED + 64'h94D049BB133111EB;
    if (s0 == 64'd0) s0 = 64'd3;
    if (s1 == 64'd0) s1 = 64'd3;
    if (s2 == 64'd0) s2 = 64'd3;
    if (s3 == 64'd0) s3 = 64'd3;
    if (s4 == 64'd0) s4 = 64'd3;
  end

  // multiplier request: only when a step is ready and unit idle
  always_comb begin
    m_start = 1'b0;
    m_a = '0;
    m_b = '0;
    m_sel2 = 1'b0;
    if (busy_r && !wait_r) begin
      unique case (ph_r)
        2'd0: begin
          m_start = bit_r[6] == 1'b0 && trig_r[bit_r[5:0]];
          m_a = ssel_r ? pr2_r : pr1_r;
          m_b = {55'd0, prime_at(bit_r[5:0])};
          m_sel2 = ssel_r;
        end
        2'd1: begin
          m_start = 1'b1;
          m_a = lane_r[ln_r];
          m_b = lane_r[ln_r];
          m_sel2 = ln_r[0];
        end
        2'd2: begin
          m_start = 1'b1;
          m_a = t_r[ln_r];
          m_b = ln_r[0] ? pr2_r : pr1_r;
          m_sel2 = ln_r[0];
        end
        default: m_start = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      wait_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.load_init) begin
        lane_r[0] <= s0; lane_r[1] <= s1; lane_r[2] <= s2;
        lane_r[3] <= s3; lane_r[4] <= s4;
      end else if (cmd.absorb) begin
        lane_r[0] <= lane_r[0] ^ absorb_word;
      end
      if (cmd.start_perm) begin
        busy_r <= 1'b1;
        wait_r <= 1'b0;
        ph_r   <= 2'd0;
        bit_r  <= '0;
        ssel_r <= 1'b0;
        ln_r   <= '0;
        pr1_r  <= 64'd1;
        pr2_r  <= 64'd1;
        trig_r <= lane_r[0] ^ lane_r[2] ^ lane_r[4] ^ TRIG_CONST;
      end else if (busy_r) begin
        if (m_start) wait_r <= 1'b1;
        unique case (ph_r)
          2'd0: begin
            if (bit_r[6]) begin
              ph_r <= 2'd1;
            end else if (!wait_r && !trig_r[bit_r[5:0]]) begin
              bit_r <= bit_r + 7'd1;
            end else if (m_done) begin
              wait_r <= 1'b0;
              if (ssel_r) pr2_r <= m_res; else pr1_r <= m_res;
              ssel_r <= ~ssel_r;
              if (ssel_r) bit_r <= bit_r + 7'd1;
            end
          end
          2'd1, 2'd2: begin
            if (m_done) begin
              wait_r <= 1'b0;
              t_r[ln_r] <= m_res;
              if (ln_r == 3'd4) begin
                ln_r <= '0;
                ph_r <= ph_r + 2'd1;
              end else begin
                ln_r <= ln_r + 3'd1;
              end
            end
          end
          default: begin
            lane_r[0] <= t_r[0] ^ {t_r[1][16:0], t_r[1][63:17]};
            lane_r[1] <= t_r[1] ^ {t_r[2][10:0], t_r[2][63:11]};
            lane_r[2] <= t_r[2] ^ {t_r[3][18:0], t_r[3][63:19]};
            lane_r[3] <= t_r[3] ^ {t_r[4][12:0], t_r[4][63:13]};
            lane_r[4] <= t_r[4] ^ {t_r[0][22:0], t_r[0][63:23]};
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        endcase
      end
    end
  end

  assign sts.perm_busy = busy_r;
  assign sts.perm_done = done_r;
  assign lane0 = lane_r[0];
endmodule

// ===== design/msh_ctrl.sv =====
module msh_ctrl import msh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] word_index,
  output logic       digest_last,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd
);
  ctl_state_t state_r, state_nxt;
  logic       emit_r, emit_nxt;
  logic [1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      emit_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    emit_nxt  = emit_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.load_init = 1'b1;
        state_nxt = ST_RELOAD;
      end
      ST_RELOAD: begin
        cmd.start_perm = 1'b1;
        emit_nxt = 1'b0;
        state_nxt = ST_WAIT;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.absorb = 1'b1;
          emit_nxt = in_last;
          idx_nxt = '0;
          state_nxt = ST_PERM;
        end
      end
      ST_PERM: begin
        cmd.start_perm = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.perm_done) state_nxt = emit_r ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            cmd.load_init = 1'b1;
            state_nxt = ST_RELOAD;
          end else begin
            state_nxt = ST_PERM;
          end
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  assign word_index  = idx_r;
  assign digest_last = idx_r == 2'd3;
endmodule

// ===== design/msh_checker.sv =====
module msh_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_word_index,
  input logic       out_digest_last
);
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digest_last == (out_word_index == 2'd3)))
    else $error("digest_last mismatch");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during output");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word_index))
    else $error("stalled result changed");
endmodule

bind modmul_sponge_hash256 msh_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_word_index(out_word_index), .out_digest_last(out_digest_last)
);
